/* rtl/core/kdb_pkg.sv */
// key debounce package: widths, defaults, phase, event and register codes
// no dependencies; used by every module of the key debounce block but the fifo
`timescale 1ns / 1ps

package kdb_pkg;

  localparam int unsigned NUM_KEYS_DEF   = 4;
  localparam int unsigned TIMER_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned MAX_EVENTS     = 4;

  localparam int unsigned CODE_W      = 3;
  localparam int unsigned CFG_TIMER_W = 16;
  localparam int unsigned EN_W        = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned REG_IDX_W   = 3;

  // key phase codes
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_WAIT_HOLD = 2'd1;
  localparam logic [1:0] PH_REPEAT    = 2'd2;

  // event codes
  localparam logic [CODE_W-1:0] EV_CLICK   = 3'd0;
  localparam logic [CODE_W-1:0] EV_HOLD    = 3'd1;
  localparam logic [CODE_W-1:0] EV_REPEAT  = 3'd2;
  localparam logic [CODE_W-1:0] EV_RELEASE = 3'd3;
  localparam logic [CODE_W-1:0] EV_PWRUP   = 3'd4;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HOLD     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ENABLES  = 3'd4;

  localparam logic [CFG_TIMER_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_TIMER_W-1:0] HOLD_RST     = 16'd1000;
  localparam logic [CFG_TIMER_W-1:0] REPEAT_RST   = 16'd200;
  localparam logic [EN_W-1:0]        ENABLES_RST  = 5'h1f;

  typedef struct packed {
    logic [CFG_TIMER_W-1:0] debounce_ticks;
    logic [CFG_TIMER_W-1:0] hold_ticks;
    logic [CFG_TIMER_W-1:0] repeat_ticks;
    logic [EN_W-1:0]        event_enables;
  } kdb_cfg_t;

endpackage

/* rtl/core/kdb_front.sv */
// key debounce front: takes a tick, updates every key's debounce and hold state
// and hands the tick's gated event set to the queue; uses kdb_pkg
`timescale 1ns / 1ps

module kdb_front import kdb_pkg::*; #(
  parameter int unsigned NUM_KEYS   = NUM_KEYS_DEF,
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [NUM_KEYS-1:0]            pin_levels_i,
  input  kdb_cfg_t                       cfg_i,
  input  logic [NUM_KEYS-1:0]            active_levels_i,
  input  logic                           full_i,
  output logic                           push_o,
  output logic [NUM_KEYS*(CODE_W+1)-1:0] push_data_o
);

  localparam int unsigned ExtW = CFG_TIMER_W + TIMER_BITS;

  function automatic logic [TIMER_BITS-1:0] load_value(input logic [CFG_TIMER_W-1:0] v);
    logic [ExtW-1:0]       ext;
    logic [TIMER_BITS-1:0] r;
    ext = ExtW'(v);
    r   = ext[TIMER_BITS-1:0];
    return (r == '0) ? TIMER_BITS'(1) : r;
  endfunction

  logic                  primed_q, primed_d;
  logic [NUM_KEYS-1:0]   prev_q, prev_d;
  logic [NUM_KEYS-1:0]   stable_q, stable_d;
  logic [TIMER_BITS-1:0] deb_q [NUM_KEYS];
  logic [TIMER_BITS-1:0] deb_d [NUM_KEYS];
  logic [TIMER_BITS-1:0] hold_q [NUM_KEYS];
  logic [TIMER_BITS-1:0] hold_d [NUM_KEYS];
  logic [1:0]            ph_q [NUM_KEYS];
  logic [1:0]            ph_d [NUM_KEYS];
  logic [NUM_KEYS-1:0]   ev_vld;

  logic [TIMER_BITS-1:0] deb_load, hold_load, rep_load;
  logic                  accept;

  assign deb_load  = load_value(cfg_i.debounce_ticks);
  assign hold_load = load_value(cfg_i.hold_ticks);
  assign rep_load  = load_value(cfg_i.repeat_ticks);

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic                  raw, pressed, lev, ev;
    logic                  active_ph;
    logic [TIMER_BITS-1:0] h1;
    logic [CODE_W-1:0]     code;
    primed_d = 1'b1;
    prev_d   = pin_levels_i;
    stable_d = stable_q;
    for (int k = 0; k < NUM_KEYS; k++) begin
      raw       = pin_levels_i[k];
      pressed   = (raw == active_levels_i[k]);
      lev       = 1'b0;
      ev        = 1'b0;
      code      = EV_CLICK;
      deb_d[k]  = deb_q[k];
      hold_d[k] = hold_q[k];
      ph_d[k]   = ph_q[k];
      active_ph = (ph_q[k] == PH_WAIT_HOLD) || (ph_q[k] == PH_REPEAT);
      h1        = '0;
      if (!primed_q) begin
        stable_d[k] = raw;
      end else begin
        if (deb_q[k] != '0) begin
          deb_d[k] = deb_q[k] - TIMER_BITS'(1);
          // debounce ends this tick: sample the pin
          if (deb_q[k] == TIMER_BITS'(1) && raw != stable_q[k]) begin
            stable_d[k] = raw;
            if (active_ph) begin
              if (!pressed) begin
                ph_d[k]   = PH_IDLE;
                hold_d[k] = '0;
                code      = EV_RELEASE;
                lev       = 1'b1;
              end
            end else if (pressed) begin
              ph_d[k]   = PH_WAIT_HOLD;
              hold_d[k] = hold_load;
              code      = EV_CLICK;
              lev       = 1'b1;
            end else begin
              ph_d[k] = PH_IDLE;
              code    = EV_PWRUP;
              lev     = 1'b1;
            end
          end
        end else if (raw != prev_q[k]) begin
          deb_d[k] = deb_load;
        end
        ev = lev;
        // hold timer runs only in an active phase on ticks without a level event
        if (!lev && active_ph) begin
          h1 = (hold_q[k] != '0) ? hold_q[k] - TIMER_BITS'(1) : '0;
          if (h1 == '0) begin
            hold_d[k] = rep_load;
            ev        = 1'b1;
            if (ph_q[k] == PH_WAIT_HOLD) begin
              ph_d[k] = PH_REPEAT;
              code    = EV_HOLD;
            end else begin
              code = EV_REPEAT;
            end
          end else begin
            hold_d[k] = h1;
          end
        end
      end
      ev_vld[k]  = ev && cfg_i.event_enables[code];
      push_data_o[k*(CODE_W+1) +: (CODE_W+1)] = {ev_vld[k], code};
    end
  end

  assign push_o = accept && primed_q && (ev_vld != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      prev_q   <= '0;
      stable_q <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        deb_q[k]  <= '0;
        hold_q[k] <= '0;
        ph_q[k]   <= PH_IDLE;
      end
    end else if (accept) begin
      primed_q <= primed_d;
      prev_q   <= prev_d;
      stable_q <= stable_d;
      for (int k = 0; k < NUM_KEYS; k++) begin
        deb_q[k]  <= deb_d[k];
        hold_q[k] <= hold_d[k];
        ph_q[k]   <= ph_d[k];
      end
    end
  end

endmodule

/* rtl/core/kdb_fifo.sv */
// key debounce event-set queue: small flip-flop fifo between front and back
// no package dependency
`timescale 1ns / 1ps

module kdb_fifo #(
  parameter int unsigned W     = 16,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/kdb_back.sv */
// key debounce back: walks one event set in key order and sends at most
// four events through the output register; uses kdb_pkg
`timescale 1ns / 1ps

module kdb_back import kdb_pkg::*; #(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF,
  parameter int unsigned KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  logic [NUM_KEYS*(CODE_W+1)-1:0] set_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [KEY_W-1:0]               key_index_o,
  output logic [CODE_W-1:0]              event_code_o,
  output logic                           last_event_o
);

  localparam int unsigned CntW = $clog2(MAX_EVENTS);

  logic                      busy_q, busy_d;
  logic [NUM_KEYS-1:0]       mask_q, mask_d;
  logic [NUM_KEYS*CODE_W-1:0] codes_q, codes_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      out_valid_q, out_valid_d;
  logic [KEY_W-1:0]          key_q, key_d;
  logic [CODE_W-1:0]         code_q, code_d;
  logic                      last_q, last_d;

  logic [NUM_KEYS-1:0]       in_mask, rest;
  logic [NUM_KEYS*CODE_W-1:0] in_codes;
  logic [KEY_W-1:0]          idx;
  logic                      advance, emit, last, load_new;

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      in_mask[k]                   = set_i[k*(CODE_W+1) + CODE_W];
      in_codes[k*CODE_W +: CODE_W] = set_i[k*(CODE_W+1) +: CODE_W];
    end
  end

  // lowest pending key goes first
  always_comb begin
    idx = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (mask_q[k]) begin
        idx = KEY_W'(k);
      end
    end
  end

  assign rest     = mask_q & ~(NUM_KEYS'(1) << idx);
  assign last     = (cnt_q == CntW'(MAX_EVENTS - 1)) || (rest == '0);
  assign advance  = !out_valid_q || out_ready_i;
  assign emit     = advance && busy_q;
  assign load_new = !empty_i && (!busy_q || (emit && last));
  assign pop_o    = load_new;

  always_comb begin
    busy_d      = busy_q;
    mask_d      = mask_q;
    codes_d     = codes_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    key_d       = key_q;
    code_d      = code_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      key_d       = idx;
      code_d      = codes_q[idx*CODE_W +: CODE_W];
      last_d      = last;
      mask_d      = rest;
      cnt_d       = cnt_q + CntW'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
    if (load_new) begin
      busy_d  = 1'b1;
      mask_d  = in_mask;
      codes_d = in_codes;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q  <= mask_d;
    codes_q <= codes_d;
    key_q   <= key_d;
    code_q  <= code_d;
    last_q  <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign key_index_o  = key_q;
  assign event_code_o = code_q;
  assign last_event_o = last_q;

endmodule

/* rtl/core/key_debounce_click_hold_repeat.sv */
// key debounce top: register file, front, event-set queue and back; uses kdb_pkg
// path: a tick's events pass the queue, then the back's set registers, then its output register
// throughput: one tick per cycle while the queue is not full; the back sends one event
// per cycle while the receiver is ready, at most 4 events per tick; a 2-entry queue absorbs bursts
// reset: async active low, all keys idle, timers stopped, first tick primes levels
`timescale 1ns / 1ps

module key_debounce_click_hold_repeat import kdb_pkg::*; #(
  parameter int unsigned NUM_KEYS   = NUM_KEYS_DEF,
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF,
  parameter int unsigned KEY_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [NUM_KEYS-1:0] pin_levels_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KEY_W-1:0]    key_index_o,
  output logic [CODE_W-1:0]   event_code_o,
  output logic                last_event_o
);

  localparam int unsigned SetW = NUM_KEYS * (CODE_W + 1);

  kdb_cfg_t              cfg_q;
  logic [NUM_KEYS-1:0]   active_q;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;

  logic                  push, full, pop, empty;
  logic [SetW-1:0]       push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= DEBOUNCE_RST;
      cfg_q.hold_ticks     <= HOLD_RST;
      cfg_q.repeat_ticks   <= REPEAT_RST;
      cfg_q.event_enables  <= ENABLES_RST;
      active_q             <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEBOUNCE: cfg_q.debounce_ticks <= pwdata[CFG_TIMER_W-1:0];
        REG_HOLD:     cfg_q.hold_ticks     <= pwdata[CFG_TIMER_W-1:0];
        REG_REPEAT:   cfg_q.repeat_ticks   <= pwdata[CFG_TIMER_W-1:0];
        REG_ACTIVE:   active_q             <= pwdata[NUM_KEYS-1:0];
        REG_ENABLES:  cfg_q.event_enables  <= pwdata[EN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE: prdata = DATA_W'(cfg_q.debounce_ticks);
      REG_HOLD:     prdata = DATA_W'(cfg_q.hold_ticks);
      REG_REPEAT:   prdata = DATA_W'(cfg_q.repeat_ticks);
      REG_ACTIVE:   prdata = DATA_W'(active_q);
      REG_ENABLES:  prdata = DATA_W'(cfg_q.event_enables);
      default:      prdata = '0;
    endcase
  end

  kdb_front #(
    .NUM_KEYS  (NUM_KEYS),
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pin_levels_i   (pin_levels_i),
    .cfg_i          (cfg_q),
    .active_levels_i(active_q),
    .full_i         (full),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  kdb_fifo #(
    .W    (SetW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (pop_data)
  );

  kdb_back #(
    .NUM_KEYS(NUM_KEYS),
    .KEY_W   (KEY_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .set_i       (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_index_o (key_index_o),
    .event_code_o(event_code_o),
    .last_event_o(last_event_o)
  );

endmodule

/* rtl/core/kdb_checker.sv */
// key debounce port checker and its bind to the top level
// uses kdb_pkg; watches only the top level's ports
`timescale 1ns / 1ps

module kdb_checker import kdb_pkg::*; #(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF,
  parameter int unsigned KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [ADDR_W-1:0]   paddr,
  input logic [DATA_W-1:0]   pwdata,
  input logic [DATA_W-1:0]   prdata,
  input logic                pready,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [KEY_W-1:0]    key_index_o,
  input logic [CODE_W-1:0]   event_code_o,
  input logic                last_event_o
);

  logic [2:0] run_q;
  logic       wr_debounce;

  assign wr_debounce = psel && penable && pwrite && pready &&
                       (paddr[ADDR_W-1:2] == REG_DEBOUNCE);

  // beats since the last one that closed a tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      run_q <= last_event_o ? 3'd0 : run_q + 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_index_o) &&
    $stable(event_code_o) && $stable(last_event_o))
    else $error("output beat changed while stalled");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_code_o == EV_CLICK) || (event_code_o == EV_HOLD) ||
    (event_code_o == EV_REPEAT) || (event_code_o == EV_RELEASE) ||
    (event_code_o == EV_PWRUP))
    else $error("event code out of range");

  a_four_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (run_q == 3'(MAX_EVENTS - 1)) |-> last_event_o)
    else $error("more than four events for one tick");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_debounce ##1 (paddr[ADDR_W-1:2] == REG_DEBOUNCE) |->
    prdata[CFG_TIMER_W-1:0] == $past(pwdata[CFG_TIMER_W-1:0]))
    else $error("debounce register read back differs from write");

endmodule

bind key_debounce_click_hold_repeat kdb_checker #(
  .NUM_KEYS(NUM_KEYS),
  .KEY_W   (KEY_W)
) u_kdb_checker (.*);

/* test/testbench.sv */
// testbench for key_debounce_click_hold_repeat: directed and random ticks against a
// cycle-free model of the key scanner, results checked beat by beat in order
// depends on kdb_pkg and the key_debounce_click_hold_repeat rtl
`timescale 1ns / 1ps

module testbench;
  import kdb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned TAIL_CYCLES     = 20;

  typedef struct packed {
    logic [1:0]        key_idx;
    logic [CODE_W-1:0] ev_code;
    logic              last_ev;
  } key_event_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [DATA_W-1:0] pwdata       = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [3:0]        pin_levels_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [1:0]        key_index_o;
  logic [CODE_W-1:0] event_code_o;
  logic              last_event_o;

  key_debounce_click_hold_repeat dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pin_levels_i (pin_levels_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .key_index_o  (key_index_o),
    .event_code_o (event_code_o),
    .last_event_o (last_event_o)
  );

  always #6 clk_i = ~clk_i;

  // model copy of the registers
  logic [15:0] cfg_debounce = DEBOUNCE_RST;
  logic [15:0] cfg_hold     = HOLD_RST;
  logic [15:0] cfg_repeat   = REPEAT_RST;
  logic [3:0]  cfg_active   = 4'd0;
  logic [4:0]  cfg_enables  = ENABLES_RST;

  // model copy of the key state
  logic        mdl_primed = 1'b0;
  logic [3:0]  mdl_prev   = '0;
  logic [3:0]  mdl_stable = '0;
  logic [15:0] mdl_deb   [4] = '{default: '0};
  logic [1:0]  mdl_phase [4] = '{default: PH_IDLE};
  logic [15:0] mdl_hold  [4] = '{default: '0};

  key_event_t key_event_q[$];
  int         n_fail      = 0;
  int         tx_gap_max  = 16;
  int         rx_gap_max  = 16;
  bit         rx_hold_req = 1'b0;

  function automatic logic [15:0] timer_load(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // one tick through the key scanner, queues the events it raises
  function automatic void scan_keys(input logic [3:0] pins);
    key_event_t        evs[MAX_EVENTS];
    int                n;
    logic              raw, pressed, fire;
    logic [1:0]        ph;
    logic [CODE_W-1:0] code;
    n = 0;
    if (!mdl_primed) begin
      mdl_prev   = pins;
      mdl_stable = pins;
      mdl_primed = 1'b1;
      return;
    end
    for (int k = 0; k < 4; k++) begin
      raw  = pins[k];
      fire = 1'b0;
      code = EV_CLICK;
      ph   = mdl_phase[k];
      if (mdl_deb[k] != 16'd0) begin
        mdl_deb[k] = mdl_deb[k] - 16'd1;
        if (mdl_deb[k] == 16'd0 && raw != mdl_stable[k]) begin
          pressed       = (raw == cfg_active[k]);
          mdl_stable[k] = raw;
          if (ph == PH_WAIT_HOLD || ph == PH_REPEAT) begin
            // still pressed after an active level rewrite: phase kept
            if (!pressed) begin
              mdl_phase[k] = PH_IDLE;
              mdl_hold[k]  = 16'd0;
              fire         = 1'b1;
              code         = EV_RELEASE;
            end
          end else if (pressed) begin
            mdl_phase[k] = PH_WAIT_HOLD;
            mdl_hold[k]  = timer_load(cfg_hold);
            fire         = 1'b1;
            code         = EV_CLICK;
          end else begin
            mdl_phase[k] = PH_IDLE;
            fire         = 1'b1;
            code         = EV_PWRUP;
          end
        end
      end else if (raw != mdl_prev[k]) begin
        mdl_deb[k] = timer_load(cfg_debounce);
      end
      mdl_prev[k] = raw;
      ph = mdl_phase[k];
      if (!fire && (ph == PH_WAIT_HOLD || ph == PH_REPEAT)) begin
        if (mdl_hold[k] != 16'd0) mdl_hold[k] = mdl_hold[k] - 16'd1;
        if (mdl_hold[k] == 16'd0) begin
          mdl_hold[k] = timer_load(cfg_repeat);
          fire        = 1'b1;
          if (ph == PH_WAIT_HOLD) begin
            mdl_phase[k] = PH_REPEAT;
            code         = EV_HOLD;
          end else begin
            code = EV_REPEAT;
          end
        end
      end
      // masked events still change state, only the beat is dropped
      if (fire && cfg_enables[code] && n < MAX_EVENTS) begin
        evs[n] = '{key_idx: 2'(k), ev_code: code, last_ev: 1'b0};
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) evs[i].last_ev = 1'b1;
      key_event_q.push_back(evs[i]);
    end
  endfunction

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_DEBOUNCE: cfg_debounce = val;
      REG_HOLD:     cfg_hold     = val;
      REG_REPEAT:   cfg_repeat   = val;
      REG_ACTIVE:   cfg_active   = val[3:0];
      REG_ENABLES:  cfg_enables  = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_timers(input logic [15:0] deb, input logic [15:0] hold,
                            input logic [15:0] rep);
    reg_write(REG_DEBOUNCE, deb);
    reg_write(REG_HOLD, hold);
    reg_write(REG_REPEAT, rep);
  endtask

  task automatic send_tick(input logic [3:0] pins);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pin_levels_i <= pins;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    scan_keys(pins);
  endtask

  task automatic send_ticks(input logic [3:0] pins, input int count);
    repeat (count) send_tick(pins);
  endtask

  // wait out every expected beat, then the pipeline, before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    while (key_event_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // priming with every key pressed, then releasing them gives power-up events
  task automatic test_power_up();
    set_timers(16'd1, 16'd3, 16'd2);
    send_tick(4'b0000);
    send_ticks(4'b0101, 2);
    send_ticks(4'b1111, 2);
    drain();
  endtask

  task automatic test_click_hold_release();
    send_ticks(4'b1110, 6);
    send_ticks(4'b1111, 2);
    drain();
  endtask

  // edges inside the debounce window are ignored
  task automatic test_debounce_glitch();
    reg_write(REG_DEBOUNCE, 16'd3);
    send_tick(4'b1011);
    send_tick(4'b1111);
    send_tick(4'b1011);
    send_tick(4'b1111);
    send_tick(4'b1011);
    send_ticks(4'b1111, 2);
    drain();
  endtask

  // all keys together: four beats per tick, in key order, then masked events
  task automatic test_all_keys();
    set_timers(16'd1, 16'd1, 16'd1);
    send_ticks(4'b0000, 4);
    send_ticks(4'b1111, 2);
    drain();
    reg_write(REG_ENABLES, 16'b10101);
    send_ticks(4'b0000, 3);
    send_ticks(4'b1111, 2);
    drain();
    reg_write(REG_ENABLES, 16'h1f);
  endtask

  // flipping the active level of a held key: the new press is ignored
  task automatic test_active_rewrite();
    send_ticks(4'b1101, 2);
    drain();
    reg_write(REG_ACTIVE, 16'b0010);
    send_ticks(4'b1111, 2);
    send_ticks(4'b1101, 2);
    drain();
    reg_write(REG_ACTIVE, 16'd0);
  endtask

  // receiver holds off while ticks keep coming, so the block fills and stalls
  task automatic test_backpressure();
    set_timers(16'd1, 16'd1, 16'd1);
    send_ticks(4'b0000, 2);
    tx_gap_max  = 0;
    rx_hold_req = 1'b1;
    send_ticks(4'b0000, 24);
    send_ticks(4'b1111, 2);
    drain();
    tx_gap_max = 16;
  endtask

  task automatic test_random_keys();
    logic [3:0] levels;
    logic [3:0] glitch;
    levels = 4'b1111;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          set_timers(16'($urandom_range(1, 3)), 16'($urandom_range(1, 6)),
                     16'($urandom_range(1, 3)));
          reg_write(REG_ACTIVE, 16'($urandom_range(0, 15)));
          tx_gap_max = 16;
          rx_gap_max = 16;
        end
        1: begin
          set_timers(16'($urandom_range(1, 3)), 16'($urandom_range(1, 6)),
                     16'($urandom_range(1, 3)));
          tx_gap_max = 0;
          rx_gap_max = 0;
        end
        2: begin
          reg_write(REG_ENABLES, 16'($urandom_range(0, 31)));
          reg_write(REG_ACTIVE, 16'($urandom_range(0, 15)));
          tx_gap_max = 3;
          rx_gap_max = 16;
        end
        3: begin
          set_timers(16'd2, 16'hffff, 16'hffff);
          reg_write(REG_ACTIVE, 16'hf);
          reg_write(REG_ENABLES, 16'd0);
          tx_gap_max = 16;
          rx_gap_max = 0;
        end
        4: begin
          set_timers(16'd2, 16'($urandom_range(1, 4)), 16'd1);
          reg_write(REG_ENABLES, 16'($urandom_range(0, 31)));
          reg_write(REG_ACTIVE, 16'($urandom_range(0, 15)));
          tx_gap_max = 0;
          rx_gap_max = 16;
        end
        default: begin
          // longest debounce last: edges from here on never settle
          set_timers(16'hffff, 16'd1, 16'd1);
          reg_write(REG_ACTIVE, 16'd0);
          reg_write(REG_ENABLES, 16'h1f);
          tx_gap_max = 16;
          rx_gap_max = 16;
        end
      endcase
      for (int i = 0; i < 33; i++) begin
        for (int k = 0; k < 4; k++)
          if ($urandom_range(0, 5) == 0) levels[k] = ~levels[k];
        glitch = '0;
        for (int k = 0; k < 4; k++)
          if ($urandom_range(0, 15) == 0) glitch[k] = 1'b1;
        if ($urandom_range(0, 7) == 0) send_tick(4'($urandom_range(0, 15)));
        else send_tick(levels ^ glitch);
      end
      drain();
    end
  endtask

  initial begin : receiver
    int gap;
    forever begin
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      gap = $urandom_range(0, rx_gap_max);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin : event_check
    key_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (key_event_q.size() == 0) begin
        $error("unexpected event beat: key %0d code %0d", key_index_o, event_code_o);
        n_fail++;
      end else begin
        want = key_event_q.pop_front();
        if (want.key_idx !== key_index_o) begin
          $error("key_index expected %0d actual %0d", want.key_idx, key_index_o);
          n_fail++;
        end
        if (want.ev_code !== event_code_o) begin
          $error("event_code expected %0d actual %0d", want.ev_code, event_code_o);
          n_fail++;
        end
        if (want.last_ev !== last_event_o) begin
          $error("last_event expected %0d actual %0d", want.last_ev, last_event_o);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned idle_cnt;
    if (!rst_ni) begin
      idle_cnt = 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                 (psel && penable && pwrite && pready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_power_up();
    test_click_hold_release();
    test_debounce_glitch();
    test_all_keys();
    test_active_rewrite();
    test_backpressure();
    test_random_keys();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_fail == 0 && key_event_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/kdb_pkg.sv
rtl/core/kdb_front.sv
rtl/core/kdb_fifo.sv
rtl/core/kdb_back.sv
rtl/core/key_debounce_click_hold_repeat.sv
rtl/core/kdb_checker.sv
test/testbench.sv
